/* design/sspq_pkg.sv */
// Shared types and constants for the stable sorted priority queue.
package sspq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_PEEK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_ENQ_CMP,
    S_ENQ_PUT
  } state_e;

  typedef struct packed {
    logic [PRIO_W-1:0]         prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* design/sspq_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module sspq_ram #(
  parameter int unsigned WIDTH = sspq_pkg::ENTRY_W,
  parameter int unsigned DEPTH = sspq_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/stable_sorted_priority_queue.sv */
// Stable sorted priority queue: a circular RAM buffer kept in descending priority order.
// Enqueue into an empty or full queue is done in IDLE; else S_ENQ_CMP walks from the tail,
// moves each lower-priority entry back one place and writes the new entry there or in S_ENQ_PUT.
// Dequeue and peek answer in S_HEAD after a RAM read; an empty error or unused action, in IDLE.
// One item is in work at a time; in_ready_o is low outside IDLE and while a result waits.
// Reset clears the count and head pointer; the RAM contents are not cleared.
module stable_sorted_priority_queue #(
  parameter int unsigned DEPTH = sspq_pkg::DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            action_i,
  input  logic signed [sspq_pkg::VALUE_W-1:0]   item_value_i,
  input  logic [sspq_pkg::PRIO_W-1:0]           item_priority_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sspq_pkg::VALUE_W-1:0]   head_value_o,
  output logic [1:0]                            status_o,
  output logic [sspq_pkg::COUNT_W-1:0]          entry_count_o,
  output logic                                  is_empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  sspq_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  sspq_pkg::action_e act_q, act_d;
  sspq_pkg::entry_t  new_q, new_d;

  logic                                out_valid_q, out_valid_d;
  logic signed [sspq_pkg::VALUE_W-1:0] head_value_q, head_value_d;
  sspq_pkg::status_e                   status_q, status_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_raddr;
  sspq_pkg::entry_t       ram_wdata;
  logic [sspq_pkg::ENTRY_W-1:0] ram_rdata;
  sspq_pkg::entry_t       rd_entry;

  logic              in_fire;
  logic              is_full;
  logic [SW-1:0]     tail_sum;
  logic [SW-1:0]     tail_wrap;
  logic [AW-1:0]     tail;
  logic [31:0]       count_ext;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  assign in_ready_o = (state_q == sspq_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CW'(DEPTH));
  assign rd_entry   = sspq_pkg::entry_t'(ram_rdata);

  // Physical slot just behind the last held entry.
  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? (tail_sum - SW'(DEPTH)) : tail_sum;
  assign tail      = tail_wrap[AW-1:0];

  sspq_ram #(
    .WIDTH(sspq_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sspq_pkg::S_IDLE: begin
        if (in_fire) begin
          case (action_i) inside
            sspq_pkg::ACT_ENQ: begin
              if (!is_full && (count_q != '0)) begin
                state_d = sspq_pkg::S_ENQ_CMP;
              end
            end
            sspq_pkg::ACT_DEQ, sspq_pkg::ACT_PEEK: begin
              if (count_q != '0) begin
                state_d = sspq_pkg::S_HEAD;
              end
            end
            default: state_d = sspq_pkg::S_IDLE;
          endcase
        end
      end
      sspq_pkg::S_HEAD: state_d = sspq_pkg::S_IDLE;
      sspq_pkg::S_ENQ_CMP: begin
        if (rd_entry.prio >= new_q.prio) begin
          state_d = sspq_pkg::S_IDLE;
        end else if (pos_q == CW'(1)) begin
          state_d = sspq_pkg::S_ENQ_PUT;
        end
      end
      sspq_pkg::S_ENQ_PUT: state_d = sspq_pkg::S_IDLE;
      default: state_d = sspq_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    count_d      = count_q;
    head_d       = head_q;
    pos_d        = pos_q;
    wr_d         = wr_q;
    rd_d         = rd_q;
    act_d        = act_q;
    new_d        = new_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    head_value_d = head_value_q;
    status_d     = status_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_q;
    ram_wdata    = new_q;
    ram_raddr    = head_q;

    unique case (state_q)
      sspq_pkg::S_IDLE: begin
        if (in_fire) begin
          new_d.value  = item_value_i;
          new_d.prio   = item_priority_i;
          head_value_d = '0;
          status_d     = sspq_pkg::ST_OK;
          case (action_i) inside
            sspq_pkg::ACT_ENQ: begin
              act_d = sspq_pkg::ACT_ENQ;
              if (is_full) begin
                status_d    = sspq_pkg::ST_FULL;
                out_valid_d = 1'b1;
              end else if (count_q == '0) begin
                ram_we          = 1'b1;
                ram_waddr       = head_q;
                ram_wdata.value = item_value_i;
                ram_wdata.prio  = item_priority_i;
                count_d         = count_q + CW'(1);
                out_valid_d     = 1'b1;
              end else begin
                // Start the walk at the last held entry.
                ram_raddr = ptr_dec(tail);
                wr_d      = tail;
                rd_d      = ptr_dec(tail);
                pos_d     = count_q;
              end
            end
            sspq_pkg::ACT_DEQ, sspq_pkg::ACT_PEEK: begin
              act_d     = sspq_pkg::action_e'(action_i);
              ram_raddr = head_q;
              if (count_q == '0) begin
                status_d    = sspq_pkg::ST_EMPTY;
                out_valid_d = 1'b1;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      sspq_pkg::S_HEAD: begin
        head_value_d = rd_entry.value;
        out_valid_d  = 1'b1;
        if (act_q == sspq_pkg::ACT_DEQ) begin
          head_d  = ptr_inc(head_q);
          count_d = count_q - CW'(1);
        end
      end
      sspq_pkg::S_ENQ_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = wr_q;
        if (rd_entry.prio >= new_q.prio) begin
          // Equal priority stays ahead, so the new entry lands here.
          ram_wdata   = new_q;
          count_d     = count_q + CW'(1);
          out_valid_d = 1'b1;
        end else begin
          ram_wdata = rd_entry;
          ram_raddr = ptr_dec(rd_q);
          wr_d      = rd_q;
          rd_d      = ptr_dec(rd_q);
          pos_d     = pos_q - CW'(1);
        end
      end
      sspq_pkg::S_ENQ_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = wr_q;
        ram_wdata   = new_q;
        count_d     = count_q + CW'(1);
        out_valid_d = 1'b1;
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sspq_pkg::S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    wr_q         <= wr_d;
    rd_q         <= rd_d;
    act_q        <= act_d;
    new_q        <= new_d;
    head_value_q <= head_value_d;
    status_q     <= status_d;
  end

  assign count_ext     = 32'(count_q);
  assign out_valid_o   = out_valid_q;
  assign head_value_o  = head_value_q;
  assign status_o      = status_q;
  assign entry_count_o = count_ext[sspq_pkg::COUNT_W-1:0];
  assign is_empty_o    = (count_q == '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("held count exceeds queue depth");

  a_walk_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sspq_pkg::S_ENQ_CMP) |-> (pos_q != '0))
    else $error("insertion walk ran past the head");

  a_put_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sspq_pkg::S_ENQ_PUT) |-> (pos_q == '0) && (wr_q == head_q))
    else $error("final insertion slot is not the head");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sspq_pkg::S_HEAD && act_q == sspq_pkg::ACT_DEQ)
      |=> (count_q == $past(count_q) - CW'(1)))
    else $error("dequeue did not decrement the count");

endmodule
